/* design/cpm_pkg.sv */
package cpm_pkg;

  // Field widths
  localparam int CMD_W     = 3;
  localparam int CHANNEL_W = 2;
  localparam int ADC_W     = 10;
  localparam int TOTAL_W   = 32;
  localparam int CUR_W     = 11;
  localparam int TICKS_W   = 16;
  localparam int MAH_W     = 21;
  localparam int REM_W     = 12;
  localparam int PHASE_W   = 8;
  localparam int OVR_W     = 2;

  // Configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int REG_W  = 2;

  localparam logic [REG_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [REG_W-1:0] REG_CUTOFF     = 2'd1;
  localparam logic [REG_W-1:0] REG_FLASH_STEP = 2'd2;

  localparam logic [CUR_W-1:0]   THRESHOLD_RESET  = 11'd50;
  localparam logic [TICKS_W-1:0] CUTOFF_RESET     = 16'd180;
  localparam logic [CUR_W-1:0]   FLASH_STEP_RESET = 11'd100;

  localparam int CHANNELS_DEFAULT = 3;

  // Seconds per hour and the reciprocal used to divide by it:
  // x / 3600 = ((x >> 4) * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam logic [REM_W-1:0] SECONDS_PER_HOUR = 12'd3600;
  localparam int               DIV_PRE_SHIFT    = 4;
  localparam int               DIV_NUM_W        = TOTAL_W - DIV_PRE_SHIFT;
  localparam int               DIV_MAGIC_W      = 29;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC  = 29'd305419897;
  localparam int               DIV_SHIFT        = 36;
  localparam int               DIV_PROD_W       = DIV_NUM_W + DIV_MAGIC_W;

  // Saturated total split into hours and leftover seconds
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;
  localparam logic [MAH_W-1:0]   SAT_MAH   = 21'd1193046;
  localparam logic [REM_W-1:0]   SAT_REM   = 12'd1695;

  localparam logic [TICKS_W-1:0] TICKS_MAX   = 16'hFFFF;
  localparam logic [OVR_W-1:0]   OVR_MAX     = 2'd3;
  localparam logic [OVR_W-1:0]   OVR_RESTART = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 3'd0,
    CMD_SECOND   = 3'd1,
    CMD_BLINK    = 3'd2,
    CMD_REENABLE = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_LOAD     = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [CUR_W-1:0]   undercurrent_threshold_ma;
    logic [TICKS_W-1:0] cutoff_ticks;
    logic [CUR_W-1:0]   flash_step_ma;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [CHANNEL_W-1:0] channel;
    logic [ADC_W-1:0]     adc_sample;
    logic [TOTAL_W-1:0]   load_value;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic                 port_on;
    logic                 led_on;
    logic [CUR_W-1:0]     current_now;
    logic [MAH_W-1:0]     charge_mah;
    logic                 store_request;
    logic [TOTAL_W-1:0]   total_now;
  } result_t;

  // Item with its load value already split into hours and leftover seconds
  typedef struct packed {
    item_t              item;
    logic [MAH_W-1:0]   load_mah;
    logic [REM_W-1:0]   load_rem;
  } div_item_t;

endpackage

/* design/cpm_cfg_regs.sv */
module cpm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpm_pkg::DATA_W-1:0]  pwdata,
  output logic [cpm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cpm_pkg::cfg_t               cfg
);

  logic                       wr_en;
  logic [cpm_pkg::REG_W-1:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[cpm_pkg::ADDR_W-1:2];

  // Write the addressed register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.undercurrent_threshold_ma <= cpm_pkg::THRESHOLD_RESET;
      cfg.cutoff_ticks              <= cpm_pkg::CUTOFF_RESET;
      cfg.flash_step_ma             <= cpm_pkg::FLASH_STEP_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        cpm_pkg::REG_THRESHOLD:
          cfg.undercurrent_threshold_ma <= pwdata[cpm_pkg::CUR_W-1:0];
        cpm_pkg::REG_CUTOFF:
          cfg.cutoff_ticks <= pwdata[cpm_pkg::TICKS_W-1:0];
        cpm_pkg::REG_FLASH_STEP:
          cfg.flash_step_ma <= pwdata[cpm_pkg::CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      cpm_pkg::REG_THRESHOLD:  prdata = cpm_pkg::DATA_W'(cfg.undercurrent_threshold_ma);
      cpm_pkg::REG_CUTOFF:     prdata = cpm_pkg::DATA_W'(cfg.cutoff_ticks);
      cpm_pkg::REG_FLASH_STEP: prdata = cpm_pkg::DATA_W'(cfg.flash_step_ma);
      default:                 prdata = '0;
    endcase
  end

endmodule

/* design/cpm_load_div.sv */
module cpm_load_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  cpm_pkg::item_t         item,
  output logic                   div_valid,
  input  logic                   div_ready,
  output cpm_pkg::div_item_t     div_item
);

  typedef struct packed {
    cpm_pkg::item_t                   item;
    logic [cpm_pkg::DIV_PROD_W-1:0]   prod;
  } prod_stage_t;

  logic                            s1_valid;
  cpm_pkg::item_t                  s1;
  logic                            s2_valid;
  prod_stage_t                     s2;
  logic                            s1_ready;
  logic                            s2_ready;
  logic                            s3_ready;
  logic [cpm_pkg::DIV_NUM_W-1:0]   num;
  logic [cpm_pkg::MAH_W-1:0]       quot;
  logic [cpm_pkg::TOTAL_W-1:0]     whole;
  logic [cpm_pkg::TOTAL_W-1:0]     rem;

  // Each stage takes a word when it is empty or its word moves on
  assign s3_ready   = !div_valid || div_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_ready = s1_ready;

  // Drop the factor of 16, then multiply by the reciprocal of 225 (3600 / 16)
  assign num = s1.load_value[cpm_pkg::TOTAL_W-1:cpm_pkg::DIV_PRE_SHIFT];

  // Take the quotient and form the leftover seconds
  assign quot  = s2.prod[cpm_pkg::DIV_SHIFT +: cpm_pkg::MAH_W];
  assign whole = cpm_pkg::TOTAL_W'(quot) * cpm_pkg::TOTAL_W'(cpm_pkg::SECONDS_PER_HOUR);
  assign rem   = s2.item.load_value - whole;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      div_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= item_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) div_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1 <= item;
    if (s2_ready) begin
      s2.item <= s1;
      s2.prod <= cpm_pkg::DIV_PROD_W'(num) * cpm_pkg::DIV_PROD_W'(cpm_pkg::DIV_MAGIC);
    end
    if (s3_ready) begin
      div_item.item     <= s2.item;
      div_item.load_mah <= quot;
      div_item.load_rem <= rem[cpm_pkg::REM_W-1:0];
    end
  end

endmodule

/* design/cpm_channel_state.sv */
module cpm_channel_state #(
  parameter int CHANNELS = cpm_pkg::CHANNELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  cpm_pkg::cfg_t       cfg,
  input  logic                div_valid,
  output logic                div_ready,
  input  cpm_pkg::div_item_t  div_item,
  output logic                result_valid,
  input  logic                result_ready,
  output cpm_pkg::result_t    result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BLINK_PROD_W = (cpm_pkg::PHASE_W - 1) + cpm_pkg::CUR_W;

  // Per-channel state
  logic [cpm_pkg::CUR_W-1:0]   current_ma         [CHANNELS];
  logic [cpm_pkg::TICKS_W-1:0] undercurrent_ticks [CHANNELS];
  logic [cpm_pkg::TOTAL_W-1:0] charge_total       [CHANNELS];
  logic [cpm_pkg::MAH_W-1:0]   charge_mah         [CHANNELS];
  logic [cpm_pkg::REM_W-1:0]   charge_rem         [CHANNELS];
  logic [cpm_pkg::MAH_W-1:0]   last_mah           [CHANNELS];
  logic [cpm_pkg::PHASE_W-1:0] blink_phase        [CHANNELS];
  logic [cpm_pkg::OVR_W-1:0]   overrun_count      [CHANNELS];
  logic                        output_enabled     [CHANNELS];
  logic                        led_lit            [CHANNELS];

  logic [cpm_pkg::CUR_W-1:0]   current_ma_next;
  logic [cpm_pkg::TICKS_W-1:0] undercurrent_ticks_next;
  logic [cpm_pkg::TOTAL_W-1:0] charge_total_next;
  logic [cpm_pkg::MAH_W-1:0]   charge_mah_next;
  logic [cpm_pkg::REM_W-1:0]   charge_rem_next;
  logic [cpm_pkg::MAH_W-1:0]   last_mah_next;
  logic [cpm_pkg::PHASE_W-1:0] blink_phase_next;
  logic [cpm_pkg::OVR_W-1:0]   overrun_count_next;
  logic                        output_enabled_next;
  logic                        led_lit_next;
  logic                        store_next;
  cpm_pkg::result_t            result_next;

  logic                        fire;
  logic                        in_range;
  logic [IDX_W-1:0]            idx;
  cpm_pkg::item_t              it;

  assign it        = div_item.item;
  assign div_ready = !result_valid || result_ready;
  assign fire      = div_valid && div_ready;
  assign in_range  = 32'(it.channel) < 32'(CHANNELS);
  assign idx       = IDX_W'(it.channel);

  // Work out the addressed channel's new state
  always_comb begin
    logic [cpm_pkg::ADC_W+1:0]     adc_x3;
    logic [cpm_pkg::CUR_W-1:0]     new_cur;
    logic [cpm_pkg::TICKS_W-1:0]   ticks_inc;
    logic [cpm_pkg::TOTAL_W:0]     total_sum;
    logic [cpm_pkg::REM_W:0]       rem_sum;
    logic [cpm_pkg::PHASE_W-1:0]   phase_inc;
    logic [BLINK_PROD_W-1:0]       flash_need;
    logic                          flash_fits;
    logic [cpm_pkg::OVR_W-1:0]     ovr_inc;

    current_ma_next         = current_ma[idx];
    undercurrent_ticks_next = undercurrent_ticks[idx];
    charge_total_next       = charge_total[idx];
    charge_mah_next         = charge_mah[idx];
    charge_rem_next         = charge_rem[idx];
    last_mah_next           = last_mah[idx];
    blink_phase_next        = blink_phase[idx];
    overrun_count_next      = overrun_count[idx];
    output_enabled_next     = output_enabled[idx];
    led_lit_next            = led_lit[idx];
    store_next              = 1'b0;

    // Scale the reading: adc * 6 / 4 = adc * 3 / 2
    adc_x3  = (cpm_pkg::ADC_W+2)'(it.adc_sample) * (cpm_pkg::ADC_W+2)'(3);
    new_cur = adc_x3[cpm_pkg::ADC_W+1:1];
    ticks_inc = (undercurrent_ticks[idx] == cpm_pkg::TICKS_MAX) ?
                undercurrent_ticks[idx] : undercurrent_ticks[idx] + 1'b1;

    total_sum = {1'b0, charge_total[idx]} + (cpm_pkg::TOTAL_W+1)'(current_ma[idx]);
    rem_sum   = {1'b0, charge_rem[idx]} + (cpm_pkg::REM_W+1)'(current_ma[idx]);

    // LED lights on an even phase while phase/2 <= current/step, i.e. (phase/2)*step <= current
    phase_inc  = blink_phase[idx] + 1'b1;
    flash_need = BLINK_PROD_W'(phase_inc[cpm_pkg::PHASE_W-1:1]) *
                 BLINK_PROD_W'(cfg.flash_step_ma);
    flash_fits = (cfg.flash_step_ma == '0) ||
                 (flash_need <= BLINK_PROD_W'(current_ma[idx]));
    ovr_inc    = (overrun_count[idx] == cpm_pkg::OVR_MAX) ?
                 overrun_count[idx] : overrun_count[idx] + 1'b1;

    case (it.command)
      cpm_pkg::CMD_SAMPLE: begin
        current_ma_next = new_cur;
        if (new_cur < cfg.undercurrent_threshold_ma) begin
          undercurrent_ticks_next = ticks_inc;
          if (ticks_inc >= cfg.cutoff_ticks) output_enabled_next = 1'b0;
        end else begin
          undercurrent_ticks_next = '0;
        end
      end
      cpm_pkg::CMD_SECOND: begin
        // Carry hours and leftover seconds along with the total
        if (total_sum[cpm_pkg::TOTAL_W]) begin
          charge_total_next = cpm_pkg::TOTAL_MAX;
          charge_mah_next   = cpm_pkg::SAT_MAH;
          charge_rem_next   = cpm_pkg::SAT_REM;
        end else begin
          charge_total_next = total_sum[cpm_pkg::TOTAL_W-1:0];
          if (rem_sum >= (cpm_pkg::REM_W+1)'(cpm_pkg::SECONDS_PER_HOUR)) begin
            charge_mah_next = charge_mah[idx] + 1'b1;
            charge_rem_next = cpm_pkg::REM_W'(rem_sum -
                              (cpm_pkg::REM_W+1)'(cpm_pkg::SECONDS_PER_HOUR));
          end else begin
            charge_rem_next = rem_sum[cpm_pkg::REM_W-1:0];
          end
        end
        if (charge_mah_next != last_mah[idx]) begin
          store_next    = 1'b1;
          last_mah_next = charge_mah_next;
        end
      end
      cpm_pkg::CMD_BLINK: begin
        blink_phase_next = phase_inc;
        led_lit_next     = 1'b0;
        if (!phase_inc[0]) begin
          if (flash_fits) begin
            led_lit_next       = 1'b1;
            overrun_count_next = '0;
          end else begin
            overrun_count_next = ovr_inc;
            if (ovr_inc >= cpm_pkg::OVR_RESTART) blink_phase_next = '0;
          end
        end
      end
      cpm_pkg::CMD_REENABLE: begin
        output_enabled_next     = 1'b1;
        led_lit_next            = 1'b1;
        undercurrent_ticks_next = '0;
      end
      cpm_pkg::CMD_CLEAR: begin
        charge_total_next = '0;
        charge_mah_next   = '0;
        charge_rem_next   = '0;
        led_lit_next      = 1'b1;
      end
      cpm_pkg::CMD_LOAD: begin
        charge_total_next = it.load_value;
        charge_mah_next   = div_item.load_mah;
        charge_rem_next   = div_item.load_rem;
      end
      default: ;
    endcase
  end

  // Build the result word; an unknown channel reports zeros beside its channel number
  always_comb begin
    result_next             = '0;
    result_next.out_channel = it.channel;
    if (in_range) begin
      result_next.port_on       = output_enabled_next;
      result_next.led_on        = led_lit_next;
      result_next.current_now   = current_ma_next;
      result_next.charge_mah    = charge_mah_next;
      result_next.store_request = store_next;
      result_next.total_now     = charge_total_next;
    end
  end

  // Commit the channel entry when the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        current_ma[c]         <= '0;
        undercurrent_ticks[c] <= '0;
        charge_total[c]       <= '0;
        charge_mah[c]         <= '0;
        charge_rem[c]         <= '0;
        last_mah[c]           <= '0;
        blink_phase[c]        <= '0;
        overrun_count[c]      <= '0;
        output_enabled[c]     <= 1'b1;
        led_lit[c]            <= 1'b1;
      end
    end else if (fire && in_range) begin
      current_ma[idx]         <= current_ma_next;
      undercurrent_ticks[idx] <= undercurrent_ticks_next;
      charge_total[idx]       <= charge_total_next;
      charge_mah[idx]         <= charge_mah_next;
      charge_rem[idx]         <= charge_rem_next;
      last_mah[idx]           <= last_mah_next;
      blink_phase[idx]        <= blink_phase_next;
      overrun_count[idx]      <= overrun_count_next;
      output_enabled[idx]     <= output_enabled_next;
      led_lit[idx]            <= led_lit_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (div_ready) begin
      result_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) result <= result_next;
  end

endmodule

/* design/charge_port_monitor.sv */
// Charging-port monitor for a set of channels.
// Item channel (item_valid / item_ready / item): each word names a channel
// and a command: sample, one-second tick, blink tick, re-enable, clear total
// or load total. Result channel (result_valid / result_ready / result): one
// word per item with the channel's output and LED state, present current,
// charge total, charge in mAh and a store request on a second tick that
// moves the mAh value.
// Thresholds sit in three registers on the APB port (byte addresses 0, 4, 8).
// Pipeline: four register stages (input, product, split load value, result).
// Throughput: one item per cycle, same channel or not, while results are taken;
// the load value's split into hours runs in a pipelined reciprocal multiplier
// ahead of the channel update, which commits a channel's state as its result
// is registered, so back-to-back items see each other's state.
// Reset: all channels hold zero current and charge, output and LED on; the
// registers return to 50 mA, 180 ticks, 100 mA.
// A stalled receiver holds the result register; the stages before it keep
// filling until full, then item_ready drops.
module charge_port_monitor #(
  parameter int CHANNELS = cpm_pkg::CHANNELS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpm_pkg::DATA_W-1:0]  pwdata,
  output logic [cpm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  cpm_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output cpm_pkg::result_t            result
);

  cpm_pkg::cfg_t       cfg;
  logic                div_valid;
  logic                div_ready;
  cpm_pkg::div_item_t  div_item;

  cpm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpm_load_div u_load_div (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .div_valid  (div_valid),
    .div_ready  (div_ready),
    .div_item   (div_item)
  );

  cpm_channel_state #(
    .CHANNELS (CHANNELS)
  ) u_channel_state (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .div_valid    (div_valid),
    .div_ready    (div_ready),
    .div_item     (div_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
